// ===== rtl/mouse_click_event_classifier_top_assert.svh =====
`ifndef MOUSE_CLICK_EVENT_CLASSIFIER_TOP_ASSERT_SVH
`define MOUSE_CLICK_EVENT_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcec assertion failed");

// Next-cycle implication, checked outside reset.
`define MCEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcec assertion failed");

`endif

// ===== rtl/mcec_pkg.sv =====
package mcec_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COORD_FIELD_W  = 12;
    localparam int BTN_W          = 3;
    localparam int TIME_W         = 19;
    localparam int WIN_W          = 16;
    localparam int WB_W           = 2;
    localparam int EVT_W          = 5;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_TDATA_W    = 8;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    typedef enum logic [1:0] {
        REG_MOUSE_PRESENT = 2'd0,
        REG_WORK_BUTTON   = 2'd1,
        REG_DC_WINDOW     = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    localparam logic [EVT_W-1:0] EVT_NONE   = 5'd0;
    localparam logic [EVT_W-1:0] EVT_DOUBLE = 5'd9;

    localparam logic             RST_MOUSE_PRESENT = 1'b1;
    localparam logic [WB_W-1:0]  RST_WORK_BUTTON   = 2'd1;
    localparam logic [WIN_W-1:0] RST_DC_WINDOW     = 16'd30;
    localparam logic [BTN_W-1:0] RST_LAST_PRESSED  = 3'd3;

endpackage

// ===== rtl/mouse_click_event_classifier_top.sv =====
// Mouse click classifier: each sample request (buttons, cursor position, time stamp in
// hundredths of a second) yields one signed event code: 9 for a double click of the work
// button, the mask for a fresh press, the negated previous mask on release, else 0. The
// block takes one sample per clock cycle; the result appears in the output register in
// the cycle after acceptance, and the input is stalled only while that register is full
// and not taken. Time differences are signed and are not corrected at the hour wrap. The
// user must write configuration over the APB port while no request is in flight; the block does not enforce it.
module mouse_click_event_classifier_top #(
    parameter int COORD_BITS = mcec_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // buttons[2:0], cursor_x[14:3], cursor_y[26:15], time_now[45:27], zero fill [47:46]
    input  logic [mcec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // event_code[4:0], zero fill [7:5]
    output logic [mcec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mcec_pkg::PADDR_W-1:0]       paddr,
    input  logic [mcec_pkg::PDATA_W-1:0]       pwdata,
    output logic [mcec_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int CW = (COORD_BITS < mcec_pkg::COORD_FIELD_W) ?
                        COORD_BITS : mcec_pkg::COORD_FIELD_W;
    localparam int BW = mcec_pkg::BTN_W;
    localparam int TW = mcec_pkg::TIME_W;
    localparam int EW = mcec_pkg::EVT_W;
    localparam int FW = mcec_pkg::COORD_FIELD_W;
    localparam int DW = TW + 1;

    logic                            r_mouse_present;
    logic [mcec_pkg::WB_W-1:0]       r_work_button;
    logic [mcec_pkg::WIN_W-1:0]      r_dc_window;

    logic [BW-1:0]                   r_prev_buttons, n_prev_buttons;
    logic [CW-1:0]                   r_prev_x, n_prev_x;
    logic [CW-1:0]                   r_prev_y, n_prev_y;
    logic [BW-1:0]                   r_last_pressed, n_last_pressed;
    logic [TW-1:0]                   r_last_time, n_last_time;
    logic                            r_out_valid;
    logic [EW-1:0]                   r_event, n_event;

    logic                            cfg_wr;
    mcec_pkg::t_reg_idx              reg_idx;
    logic                            in_acc;
    logic [BW-1:0]                   btn;
    logic [CW-1:0]                   cx, cy;
    logic [TW-1:0]                   now;
    logic [BW-1:0]                   wb;
    logic                            moved, fresh;
    logic signed [DW-1:0]            diff;
    logic                            in_window;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = mcec_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mouse_present <= mcec_pkg::RST_MOUSE_PRESENT;
            r_work_button   <= mcec_pkg::RST_WORK_BUTTON;
            r_dc_window     <= mcec_pkg::RST_DC_WINDOW;
        end else if (cfg_wr) begin
            case (reg_idx)
                mcec_pkg::REG_MOUSE_PRESENT: r_mouse_present <= pwdata[0];
                mcec_pkg::REG_WORK_BUTTON:   r_work_button   <= pwdata[1:0];
                mcec_pkg::REG_DC_WINDOW:     r_dc_window     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mcec_pkg::REG_MOUSE_PRESENT: prdata = {31'd0, r_mouse_present};
            mcec_pkg::REG_WORK_BUTTON:   prdata = {30'd0, r_work_button};
            mcec_pkg::REG_DC_WINDOW:     prdata = {16'd0, r_dc_window};
            default:                     prdata = '0;
        endcase
    end

    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    assign btn = s_axis_tdata[BW-1:0];
    assign cx  = s_axis_tdata[BW +: CW];
    assign cy  = s_axis_tdata[BW + FW +: CW];
    assign now = s_axis_tdata[BW + 2*FW +: TW];

    // The work button register is clamped to the left or right button.
    assign wb = (r_work_button[1]) ? BW'(2) :
                (r_work_button == 2'd0) ? BW'(1) : BW'(r_work_button);

    assign moved     = (cx != r_prev_x) | (cy != r_prev_y);
    assign fresh     = moved | (r_prev_buttons == '0);
    assign diff      = $signed({1'b0, now}) - $signed({1'b0, r_last_time});
    assign in_window = diff < $signed(DW'({1'b0, r_dc_window}));

    always_comb begin
        n_prev_buttons = r_prev_buttons;
        n_prev_x       = r_prev_x;
        n_prev_y       = r_prev_y;
        n_last_pressed = r_last_pressed;
        n_last_time    = r_last_time;
        n_event        = mcec_pkg::EVT_NONE;
        if (r_mouse_present) begin
            if (btn == wb) begin
                if ((r_last_pressed == wb) && (r_prev_buttons == '0) && !moved &&
                    in_window) begin
                    n_last_time    = '0;
                    n_last_pressed = '0;
                    n_event        = mcec_pkg::EVT_DOUBLE;
                end else if (fresh) begin
                    n_last_time    = now;
                    n_last_pressed = wb;
                    n_event        = EW'(wb);
                end
            end else if (btn == '0) begin
                n_event = -EW'(r_prev_buttons);
            end else begin
                n_last_pressed = btn;
                n_event        = fresh ? EW'(btn) : mcec_pkg::EVT_NONE;
            end
            n_prev_buttons = btn;
            n_prev_x       = cx;
            n_prev_y       = cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_last_pressed <= mcec_pkg::RST_LAST_PRESSED;
            r_last_time    <= '0;
        end else if (in_acc) begin
            r_prev_buttons <= n_prev_buttons;
            r_prev_x       <= n_prev_x;
            r_prev_y       <= n_prev_y;
            r_last_pressed <= n_last_pressed;
            r_last_time    <= n_last_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_event <= n_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_event};

endmodule

// ===== rtl/mcec_checker.sv =====
`include "mouse_click_event_classifier_top_assert.svh"

module mcec_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mcec_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic out_stall;
    logic in_acc;
    logic neg_ok;
    logic code_ok;

    assign out_stall = m_axis_tvalid & ~m_axis_tready;
    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign neg_ok    = (m_axis_tdata[3] == 1'b1) && (m_axis_tdata[2:0] != 3'd0);
    assign code_ok   = (m_axis_tdata[7:5] == 3'd0) &&
                       (m_axis_tdata[4] ? neg_ok : (m_axis_tdata[3:0] <= 4'd9));

    // A stalled result keeps its value until it is taken.
    `MCEC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // The input is never stalled while the output register is empty.
    `MCEC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // Every accepted request shows a result in the next cycle.
    `MCEC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_acc, m_axis_tvalid)

    // Codes stay within -7..9 and the fill bits are zero.
    `MCEC_ASSERT_NOW(a_code_range, i_clk, i_rst_n, m_axis_tvalid, code_ok)

endmodule

bind mouse_click_event_classifier_top mcec_checker u_mcec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_mouse_click_event_classifier_top.sv =====
`timescale 1ns / 100ps

module tb_mouse_click_event_classifier_top;

    localparam int CYCLE_LIMIT = 300000;
    localparam int STAMP_MAX   = 359999;

    typedef struct {
        logic [mcec_pkg::BTN_W-1:0]         btn;
        logic [mcec_pkg::COORD_FIELD_W-1:0] x;
        logic [mcec_pkg::COORD_FIELD_W-1:0] y;
        logic [mcec_pkg::TIME_W-1:0]        stamp;
        int unsigned                        gap;
    } t_sample;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [mcec_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [mcec_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             psel          = 1'b0;
    logic                             penable       = 1'b0;
    logic                             pwrite        = 1'b0;
    logic [mcec_pkg::PADDR_W-1:0]     paddr         = '0;
    logic [mcec_pkg::PDATA_W-1:0]     pwdata        = '0;
    logic [mcec_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;

    t_sample                    sample_queue[$];
    logic [mcec_pkg::EVT_W-1:0] pending_events[$];
    t_sample                    cur_sample;
    logic             have_cur      = 1'b0;
    int unsigned      gap_left      = 0;
    logic             sample_taken  = 1'b0;

    logic             tx_idle_en    = 1'b1;
    logic             rx_idle_en    = 1'b1;
    logic             long_hold_req = 1'b0;
    logic             long_hold_done = 1'b0;
    int unsigned      hold_left     = 0;
    int unsigned      stall_left    = 0;

    int               error_count   = 0;
    int unsigned      cycle_count   = 0;

    logic                       cfg_present     = mcec_pkg::RST_MOUSE_PRESENT;
    logic [mcec_pkg::WB_W-1:0]  cfg_work_button = mcec_pkg::RST_WORK_BUTTON;
    logic [mcec_pkg::WIN_W-1:0] cfg_window      = mcec_pkg::RST_DC_WINDOW;

    logic [mcec_pkg::BTN_W-1:0]         last_buttons   = '0;
    logic [mcec_pkg::COORD_FIELD_W-1:0] last_x         = '0;
    logic [mcec_pkg::COORD_FIELD_W-1:0] last_y         = '0;
    logic [mcec_pkg::BTN_W-1:0]         last_press_btn = mcec_pkg::RST_LAST_PRESSED;
    logic [mcec_pkg::TIME_W-1:0]        press_stamp    = '0;

    int               stamp_now = 0;
    logic [11:0]      cur_x     = 12'd300;
    logic [11:0]      cur_y     = 12'd200;

    mouse_click_event_classifier_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [mcec_pkg::EVT_W-1:0] classify_sample(
            input logic [mcec_pkg::BTN_W-1:0] btn,
            input logic [11:0] x, input logic [11:0] y,
            input logic [mcec_pkg::TIME_W-1:0] stamp);
        logic [mcec_pkg::BTN_W-1:0] wb;
        logic                       moved;
        logic                       fresh;
        int                         now_val;
        int                         press_val;
        int                         win_val;
        logic [mcec_pkg::EVT_W-1:0] ev;
        ev = mcec_pkg::EVT_NONE;
        if (!cfg_present) begin
            return mcec_pkg::EVT_NONE;
        end
        if (cfg_work_button == 2'd0) begin
            wb = 3'd1;
        end else if (cfg_work_button == 2'd3) begin
            wb = 3'd2;
        end else begin
            wb = {1'b0, cfg_work_button};
        end
        moved = (x != last_x) || (y != last_y);
        fresh = moved || (last_buttons == 3'd0);
        if (btn == wb) begin
            now_val = int'(stamp);
            press_val = int'(press_stamp);
            win_val = int'(cfg_window);
            if (last_press_btn == wb && last_buttons == 3'd0 && !moved
                    && (now_val - press_val) < win_val) begin
                press_stamp = '0;
                last_press_btn = '0;
                ev = mcec_pkg::EVT_DOUBLE;
            end else if (fresh) begin
                press_stamp = stamp;
                last_press_btn = wb;
                ev = {2'b00, wb};
            end
        end else if (btn == 3'd0) begin
            ev = 5'd0 - {2'b00, last_buttons};
        end else begin
            last_press_btn = btn;
            ev = fresh ? {2'b00, btn} : mcec_pkg::EVT_NONE;
        end
        last_buttons = btn;
        last_x = x;
        last_y = y;
        return ev;
    endfunction

    function automatic int unsigned idle_length();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic add_sample(input logic [2:0] btn, input logic [11:0] x, input logic [11:0] y,
            input int stamp);
        t_sample s;
        s.btn = btn;
        s.x = x;
        s.y = y;
        s.stamp = stamp[mcec_pkg::TIME_W-1:0];
        s.gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        sample_queue.push_back(s);
    endtask

    task automatic advance_stamp();
        if ($urandom_range(0, 49) == 0) begin
            stamp_now = int'($urandom_range(0, 524287));
        end else begin
            stamp_now = stamp_now + int'($urandom_range(0, 15));
            if (stamp_now > STAMP_MAX) begin
                stamp_now = stamp_now - (STAMP_MAX + 1);
            end
        end
    endtask

    task automatic gen_random(input int count);
        int          made;
        int          pick;
        int          win;
        int          span;
        logic [2:0]  wb;
        made = 0;
        while (made < count) begin
            pick = int'($urandom_range(0, 99));
            win = int'(cfg_window);
            wb = (cfg_work_button == 2'd0) ? 3'd1 :
                 (cfg_work_button == 2'd3) ? 3'd2 : {1'b0, cfg_work_button};
            if ($urandom_range(0, 3) == 0) begin
                cur_x = 12'($urandom_range(0, 4095));
                cur_y = 12'($urandom_range(0, 4095));
            end
            advance_stamp();
            if (pick < 45) begin
                // Press, release, press again and release, mostly at one spot, straddling the window.
                if ($urandom_range(0, 9) < 7 && win > 0) begin
                    span = int'($urandom_range(0, win - 1));
                end else begin
                    span = win + int'($urandom_range(0, 40));
                end
                if ($urandom_range(0, 9) == 0) begin
                    wb = 3'($urandom_range(1, 7));
                end
                add_sample(wb, cur_x, cur_y, stamp_now);
                add_sample(3'd0, cur_x, cur_y, stamp_now + int'($urandom_range(0, span)));
                if ($urandom_range(0, 9) == 0) begin
                    cur_x = cur_x ^ (12'd1 << $urandom_range(0, 11));
                end
                add_sample(wb, cur_x, cur_y, stamp_now + span);
                add_sample(3'd0, cur_x, cur_y, stamp_now + span + int'($urandom_range(0, 10)));
                stamp_now = (stamp_now + span) % (STAMP_MAX + 1);
                made = made + 4;
            end else if (pick < 70) begin
                if ($urandom_range(0, 1) == 0) begin
                    cur_x = cur_x + 12'($urandom_range(0, 2));
                end
                add_sample($urandom_range(0, 1) ? wb : 3'd0, cur_x, cur_y, stamp_now);
                made = made + 1;
            end else if (pick < 85) begin
                add_sample(3'($urandom_range(1, 7)), cur_x, cur_y, stamp_now);
                add_sample(3'($urandom_range(0, 7)), cur_x, cur_y, stamp_now + 1);
                made = made + 2;
            end else begin
                add_sample(3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)),
                           12'($urandom_range(0, 4095)), int'($urandom_range(0, 524287)));
                made = made + 1;
            end
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (sample_queue.size() != 0 || have_cur || s_axis_tvalid
                   || pending_events.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input mcec_pkg::t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == mcec_pkg::REG_MOUSE_PRESENT) ? 32'h1 :
               (idx == mcec_pkg::REG_WORK_BUTTON) ? 32'h3 : 32'hFFFF;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        case (idx)
            mcec_pkg::REG_MOUSE_PRESENT: cfg_present = value[0];
            mcec_pkg::REG_WORK_BUTTON:   cfg_work_button = value[mcec_pkg::WB_W-1:0];
            mcec_pkg::REG_DC_WINDOW:     cfg_window = value[mcec_pkg::WIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        if (prdata !== (value & mask)) begin
            $error("register %s readback: expected %0d, actual %0d", idx.name(),
                   value & mask, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !sample_taken) begin
            s_axis_tvalid <= 1'b1;
        end else begin
            if (!have_cur && sample_queue.size() != 0) begin
                cur_sample = sample_queue.pop_front();
                gap_left = cur_sample.gap;
                have_cur = 1'b1;
            end
            if (have_cur && gap_left == 0) begin
                s_axis_tdata <= {2'b00, cur_sample.stamp, cur_sample.y, cur_sample.x,
                                 cur_sample.btn};
                s_axis_tvalid <= 1'b1;
                have_cur = 1'b0;
            end else begin
                if (have_cur) begin
                    gap_left = gap_left - 1;
                end
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = 400;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = idle_length() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [mcec_pkg::EVT_W-1:0] want;
        if (!i_rst_n) begin
            sample_taken <= 1'b0;
        end else begin
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected result with event_code %0d",
                           $signed(m_axis_tdata[mcec_pkg::EVT_W-1:0]));
                    error_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (m_axis_tdata[mcec_pkg::EVT_W-1:0] !== want) begin
                        $error("event_code mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(m_axis_tdata[mcec_pkg::EVT_W-1:0]));
                        error_count++;
                    end
                end
            end
            sample_taken <= s_axis_tvalid && (s_axis_tready === 1'b1);
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                pending_events.push_back(classify_sample(s_axis_tdata[2:0], s_axis_tdata[14:3],
                                                         s_axis_tdata[26:15],
                                                         s_axis_tdata[45:27]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mouse_click_event_classifier_top verification failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: work button 1, window 30.
        add_sample(3'd1, 12'd100, 12'd200, 1000);
        add_sample(3'd0, 12'd100, 12'd200, 1005);
        add_sample(3'd1, 12'd100, 12'd200, 1010);
        add_sample(3'd0, 12'd100, 12'd200, 1012);
        add_sample(3'd1, 12'd100, 12'd200, 1020);
        add_sample(3'd0, 12'd100, 12'd200, 1025);
        add_sample(3'd1, 12'd100, 12'd200, 1055);
        add_sample(3'd1, 12'd100, 12'd200, 1056);
        add_sample(3'd1, 12'd101, 12'd200, 1057);
        add_sample(3'd7, 12'd4095, 12'd4095, 1060);
        add_sample(3'd7, 12'd4095, 12'd4095, 1061);
        add_sample(3'd0, 12'd4095, 12'd4095, 1062);
        add_sample(3'd2, 12'd0, 12'd0, 524287);
        add_sample(3'd3, 12'd0, 12'd0, 0);
        add_sample(3'd0, 12'd0, 12'd0, 0);
        add_sample(3'd4, 12'd5, 12'd9, 77);
        add_sample(3'd5, 12'd6, 12'd9, 78);
        add_sample(3'd6, 12'd6, 12'd10, 79);
        add_sample(3'd0, 12'd6, 12'd10, 80);
        // A press just before the hour wrap and another just after it.
        add_sample(3'd1, 12'd2730, 12'd1365, 359990);
        add_sample(3'd0, 12'd2730, 12'd1365, 359995);
        add_sample(3'd1, 12'd2730, 12'd1365, 5);
        add_sample(3'd0, 12'd2730, 12'd1365, 8);
        add_sample(3'd0, 12'd2730, 12'd1365, 9);
        wait_idle();

        apb_write(mcec_pkg::REG_WORK_BUTTON, 32'd2);
        apb_write(mcec_pkg::REG_DC_WINDOW, 32'd100);
        gen_random(120);
        wait_idle();

        apb_write(mcec_pkg::REG_WORK_BUTTON, 32'd0);
        apb_write(mcec_pkg::REG_DC_WINDOW, 32'd0);
        tx_idle_en = 1'b0;
        gen_random(90);
        wait_idle();

        apb_write(mcec_pkg::REG_WORK_BUTTON, 32'd3);
        apb_write(mcec_pkg::REG_DC_WINDOW, 32'd65535);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b0;
        long_hold_req = 1'b1;
        gen_random(120);
        wait_idle();

        apb_write(mcec_pkg::REG_MOUSE_PRESENT, 32'd0);
        rx_idle_en = 1'b1;
        gen_random(60);
        wait_idle();

        apb_write(mcec_pkg::REG_MOUSE_PRESENT, 32'd1);
        apb_write(mcec_pkg::REG_WORK_BUTTON, 32'd1);
        apb_write(mcec_pkg::REG_DC_WINDOW, 32'd1);
        gen_random(100);
        wait_idle();

        apb_write(mcec_pkg::REG_WORK_BUTTON, 32'd2);
        apb_write(mcec_pkg::REG_DC_WINDOW, 32'd30);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        gen_random(100);
        wait_idle();

        apb_write(mcec_pkg::REG_WORK_BUTTON, 32'd1);
        apb_write(mcec_pkg::REG_DC_WINDOW, 32'd45);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        gen_random(110);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("mouse_click_event_classifier_top verification clean");
        end else begin
            $display("mouse_click_event_classifier_top verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mcec_pkg.sv
rtl/mouse_click_event_classifier_top.sv
rtl/mcec_checker.sv
sim/tb_mouse_click_event_classifier_top.sv
